/* hw/rtl/ght_pkg.sv */
// shared types and constants for the generational handle table
// no dependencies
`default_nettype none
package ght_pkg;
   localparam int SLOTS_DEF = 64;
   localparam int CNT_W = 7;

   localparam logic [2:0] MODE_CREATE   = 3'd0;
   localparam logic [2:0] MODE_VALIDATE = 3'd1;
   localparam logic [2:0] MODE_DESTROY  = 3'd2;
   localparam logic [2:0] MODE_RELEASE  = 3'd3;
   localparam logic [2:0] MODE_SCENE    = 3'd4;
   localparam logic [2:0] MODE_RESOLVE  = 3'd5;

   localparam logic [2:0] ST_OK       = 3'd0;
   localparam logic [2:0] ST_INVALID  = 3'd1;
   localparam logic [2:0] ST_LIMIT    = 3'd2;
   localparam logic [2:0] ST_HANDLE   = 3'd3;
   localparam logic [2:0] ST_DENIED   = 3'd4;
   localparam logic [2:0] ST_CAPACITY = 3'd5;

   localparam logic [2:0] DT_NONE     = 3'd0;
   localparam logic [2:0] DT_RANGE    = 3'd1;
   localparam logic [2:0] DT_RELEASED = 3'd2;
   localparam logic [2:0] DT_STALE    = 3'd3;
   localparam logic [2:0] DT_SCENE    = 3'd4;
   localparam logic [2:0] DT_KIND     = 3'd5;
   localparam logic [2:0] DT_TOTAL    = 3'd6;

   localparam logic CSR_PER_OWNER = 1'b0;
   localparam logic CSR_TOTAL     = 1'b1;

   typedef struct packed {
      logic [2:0]  mode;
      logic [2:0]  kind;
      logic [7:0]  owner_id;
      logic [2:0]  handle_kind;
      logic [7:0]  handle_slot;
      logic [31:0] handle_generation;
      logic [31:0] handle_scene;
   } req_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [2:0]  detail;
      logic [2:0]  new_kind;
      logic [5:0]  new_slot;
      logic [31:0] new_generation;
      logic [31:0] new_scene;
      logic [6:0]  released_count;
      logic        alive;
      logic [7:0]  owner_out;
   } rsp_type;
endpackage
`default_nettype wire

/* hw/rtl/ght_front.sv */
// front end: request intake and two-entry queue toward the slot engine
// depends on ght_pkg
`default_nettype none
module ght_front
   import ght_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_stall,
   input  wire req_type req_data,
   output logic         q_valid,
   input  wire logic    q_pop,
   output req_type      q_data
);
   req_type    mem_ff [2];
   logic [1:0] cnt_ff, cnt_in;
   logic       wp_ff, rp_ff;
   logic       push;

   assign req_stall = cnt_ff[1];
   assign push = req_valid && !req_stall;
   assign q_valid = cnt_ff != 2'd0;
   assign q_data = mem_ff[rp_ff];

   always_comb begin
      cnt_in = cnt_ff;
      if (push && !(q_pop && q_valid)) cnt_in = cnt_ff + 2'd1;
      else if (!push && q_pop && q_valid) cnt_in = cnt_ff - 2'd1;
   end

   always_ff @(posedge clock) begin
      if (push) mem_ff[wp_ff] <= req_data;
      if (reset) begin
         cnt_ff <= 2'd0;
         wp_ff <= 1'b0;
         rp_ff <= 1'b0;
      end else begin
         cnt_ff <= cnt_in;
         if (push) wp_ff <= !wp_ff;
         if (q_pop && q_valid) rp_ff <= !rp_ff;
      end
   end
endmodule
`default_nettype wire

/* hw/rtl/ght_engine.sv */
// back end: slot storage and a sequencer that walks the slots
// depends on ght_pkg
`default_nettype none
module ght_engine
   import ght_pkg::*;
#(
   parameter int SLOTS = SLOTS_DEF
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       q_valid,
   output logic            q_pop,
   input  wire req_type    q_data,
   input  wire logic [6:0] max_per_owner,
   input  wire logic [6:0] max_total,
   output logic            rsp_valid,
   input  wire logic       rsp_stall,
   output rsp_type         rsp_data
);
   localparam int IW = $clog2(SLOTS);
   localparam int HW = $clog2(SLOTS + 1);

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_SCAN = 3'd1;
   localparam logic [2:0] S_READ = 3'd2;
   localparam logic [2:0] S_CHK  = 3'd3;
   localparam logic [2:0] S_DONE = 3'd4;

   logic [SLOTS-1:0] used_ff;
   logic [2:0]  kind_mem [SLOTS];
   logic [7:0]  owner_mem [SLOTS];
   logic [31:0] gen_mem [SLOTS];
   logic [31:0] scene_mem [SLOTS];
   logic [SLOTS-1:0] genv_ff;

   logic [2:0]    state_ff;
   req_type       cur_ff;
   logic [HW-1:0] hw_ff, live_ff, idx_ff;
   logic [HW-1:0] cnt_ff, free_ff;
   logic          found_ff;
   logic          pick_ff;
   logic [31:0]   scn_ff;
   logic [2:0]    rk_ff;
   logic [7:0]    ro_ff;
   logic [31:0]   rg_ff, rs_ff;
   rsp_type       out_ff;
   logic          ov_ff;

   logic [IW-1:0] ix;
   logic [31:0]   gcur, gnext;
   logic          match;

   assign ix = idx_ff[IW-1:0];
   assign rsp_valid = ov_ff;
   assign rsp_data = out_ff;
   assign q_pop = state_ff == S_IDLE && q_valid && !ov_ff;

   always_comb begin
      gcur = genv_ff[ix] ? rg_ff : 32'd1;
      gnext = gcur + 32'd1;
      if (gnext == 32'd0) gnext = 32'd1;
   end

   // prefetch slot contents at idx during scans and reads
   always_ff @(posedge clock) begin
      rk_ff <= kind_mem[ix];
      ro_ff <= owner_mem[ix];
      rg_ff <= gen_mem[ix];
      rs_ff <= scene_mem[ix];
   end

   logic walk_end;
   assign walk_end = idx_ff >= hw_ff;
   assign match = used_ff[ix] && (cur_ff.mode == MODE_SCENE || ro_ff == cur_ff.owner_id);

   logic [2:0] hd;
   always_comb begin
      if ({{(8-IW){1'b0}}, idx_ff[IW-1:0]} != cur_ff.handle_slot
          || cur_ff.handle_slot >= {{(8-HW){1'b0}}, hw_ff}) hd = DT_RANGE;
      else if (!used_ff[ix]) hd = DT_RELEASED;
      else if (gcur != cur_ff.handle_generation) hd = DT_STALE;
      else if (cur_ff.handle_scene != scn_ff || rs_ff != scn_ff) hd = DT_SCENE;
      else hd = DT_NONE;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         used_ff <= '0;
         genv_ff <= '0;
         hw_ff <= '0;
         live_ff <= '0;
         scn_ff <= 32'd1;
         ov_ff <= 1'b0;
         idx_ff <= '0;
      end else begin
         if (ov_ff && !rsp_stall) ov_ff <= 1'b0;
         unique case (state_ff)
            S_IDLE: begin
               if (q_pop) begin
                  cur_ff <= q_data;
                  cnt_ff <= '0;
                  found_ff <= 1'b0;
                  pick_ff <= 1'b0;
                  free_ff <= '0;
                  if (q_data.mode == MODE_VALIDATE || q_data.mode == MODE_DESTROY
                      || q_data.mode == MODE_RESOLVE) begin
                     out_ff <= '0;
                     idx_ff <= HW'(q_data.handle_slot[IW-1:0]);
                     state_ff <= S_READ;
                  end else if (q_data.mode == MODE_CREATE && q_data.owner_id != 8'd0
                               || q_data.mode == MODE_RELEASE
                               || q_data.mode == MODE_SCENE) begin
                     out_ff <= '0;
                     idx_ff <= '0;
                     state_ff <= S_READ;
                  end else begin
                     out_ff <= '{status: ST_INVALID, default: '0};
                     state_ff <= S_DONE;
                  end
               end
            end
            S_READ: state_ff <= (cur_ff.mode == MODE_VALIDATE || cur_ff.mode == MODE_DESTROY
                                 || cur_ff.mode == MODE_RESOLVE || pick_ff) ? S_CHK : S_SCAN;
            S_SCAN: begin
               if (walk_end) begin
                  if (cur_ff.mode == MODE_CREATE) begin
                     if (max_per_owner != 7'd0 && 7'(cnt_ff) >= max_per_owner) begin
                        out_ff.status <= ST_LIMIT;
                        state_ff <= S_DONE;
                     end else if (max_total != 7'd0 && 7'(live_ff) >= max_total) begin
                        out_ff.status <= ST_LIMIT;
                        out_ff.detail <= DT_TOTAL;
                        state_ff <= S_DONE;
                     end else if (!found_ff && hw_ff >= HW'(SLOTS)) begin
                        out_ff.status <= ST_CAPACITY;
                        state_ff <= S_DONE;
                     end else begin
                        // read the chosen slot once more before claiming it
                        idx_ff <= found_ff ? free_ff : hw_ff;
                        pick_ff <= 1'b1;
                        state_ff <= S_READ;
                     end
                  end else begin
                     out_ff.released_count <= 7'(cnt_ff);
                     if (cur_ff.mode == MODE_SCENE) begin
                        live_ff <= '0;
                        scn_ff <= (scn_ff + 32'd1 == 32'd0) ? 32'd1 : scn_ff + 32'd1;
                     end else live_ff <= live_ff - cnt_ff;
                     state_ff <= S_DONE;
                  end
               end else begin
                  if (cur_ff.mode == MODE_CREATE) begin
                     if (used_ff[ix] && ro_ff == cur_ff.owner_id) cnt_ff <= cnt_ff + 1'b1;
                     if (!used_ff[ix] && !found_ff) begin
                        found_ff <= 1'b1;
                        free_ff <= idx_ff;
                     end
                  end else if (match) begin
                     cnt_ff <= cnt_ff + 1'b1;
                     used_ff[ix] <= 1'b0;
                     owner_mem[ix] <= 8'd0;
                     gen_mem[ix] <= gnext;
                     genv_ff[ix] <= 1'b1;
                  end
                  idx_ff <= idx_ff + 1'b1;
                  state_ff <= S_READ;
               end
            end
            S_CHK: begin
               state_ff <= S_DONE;
               if (cur_ff.mode == MODE_CREATE) begin
                  used_ff[ix] <= 1'b1;
                  kind_mem[ix] <= cur_ff.kind;
                  owner_mem[ix] <= cur_ff.owner_id;
                  scene_mem[ix] <= scn_ff;
                  live_ff <= live_ff + 1'b1;
                  if (idx_ff == hw_ff) hw_ff <= hw_ff + 1'b1;
                  out_ff.new_kind <= cur_ff.kind;
                  out_ff.new_slot <= 6'(idx_ff);
                  out_ff.new_generation <= gcur;
                  out_ff.new_scene <= scn_ff;
               end else if (cur_ff.mode == MODE_RESOLVE) begin
                  if (hd == DT_NONE) begin
                     out_ff.alive <= 1'b1;
                     out_ff.owner_out <= ro_ff;
                  end
               end else if (hd != DT_NONE) begin
                  out_ff.status <= ST_HANDLE;
                  out_ff.detail <= hd;
               end else if (cur_ff.mode == MODE_VALIDATE
                            ? (cur_ff.handle_kind != cur_ff.kind || rk_ff != cur_ff.kind)
                            : (rk_ff != cur_ff.handle_kind)) begin
                  out_ff.status <= ST_HANDLE;
                  out_ff.detail <= DT_KIND;
               end else if (ro_ff != cur_ff.owner_id)
                  out_ff.status <= ST_DENIED;
               else if (cur_ff.mode == MODE_DESTROY) begin
                  used_ff[ix] <= 1'b0;
                  owner_mem[ix] <= 8'd0;
                  gen_mem[ix] <= gnext;
                  genv_ff[ix] <= 1'b1;
                  if (live_ff != '0) live_ff <= live_ff - 1'b1;
               end
            end
            S_DONE: begin
               if (!ov_ff || !rsp_stall) begin
                  ov_ff <= 1'b1;
                  state_ff <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end
endmodule
`default_nettype wire

/* hw/rtl/generational_handle_table.sv */
// channel  dir  handshake      payload
// req      in   valid/stall    req_type
// rsp      out  valid/stall    rsp_type
// csr      in   valid/ready    index, data
// release owner, scene invalidation and create walk the slots below high_water, reading
// each slot in S_READ and inspecting it in S_SCAN; a create that passes its limits then
// rereads the chosen slot and claims it in S_CHK; validate, destroy and resolve check
// only the handle's slot; a two-entry queue holds requests; synchronous active-high reset;
// slot generations read as one until freed; a stalled response holds the engine but the
// queue accepts requests until both entries fill; depends on ght_pkg, ght_front, ght_engine
`default_nettype none
module generational_handle_table
   import ght_pkg::*;
#(
   parameter int SLOTS = SLOTS_DEF
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_stall,
   input  wire req_type    req_data,
   output logic            rsp_valid,
   input  wire logic       rsp_stall,
   output rsp_type         rsp_data,
   input  wire logic       csr_valid,
   output logic            csr_ready,
   input  wire logic       csr_index,
   input  wire logic [6:0] csr_data
);
   logic [6:0] per_owner_ff, total_ff;
   logic       q_valid, q_pop;
   req_type    q_data;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         per_owner_ff <= '0;
         total_ff <= '0;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_PER_OWNER: per_owner_ff <= csr_data;
            CSR_TOTAL:     total_ff <= csr_data;
            default: ;
         endcase
      end
   end

   ght_front u_front (
      .clock, .reset, .req_valid, .req_stall, .req_data,
      .q_valid, .q_pop, .q_data
   );

   ght_engine #(.SLOTS(SLOTS)) u_engine (
      .clock, .reset, .q_valid, .q_pop, .q_data,
      .max_per_owner(per_owner_ff), .max_total(total_ff),
      .rsp_valid, .rsp_stall, .rsp_data
   );

`ifndef SYNTHESIS
   a_pop_needs_data: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> q_valid) else $error("pop from empty queue");
   a_rsp_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("response changed under stall");
   a_ok_create: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.new_generation != 32'd0 |-> rsp_data.new_scene != 32'd0)
      else $error("created handle with zero scene");
`endif
endmodule
`default_nettype wire
